@@ rtl/tfr_pkg.sv @@
// Package for the telemetry frame receiver: sync codes, frame length,
// queue sizing and the decoded frame record passed from front to back.
// No dependencies.
package tfr_pkg;

    localparam logic [7:0] SYNC_FIRST     = 8'hEE;
    localparam logic [7:0] SYNC_SECOND    = 8'h16;
    localparam int         FRAME_BYTES    = 32;
    localparam int         POS_W          = $clog2(FRAME_BYTES);
    localparam logic [7:0] ZOOM_HIGH_MASK = 8'h0F;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic KIND_VALID     = 1'b0;
    localparam logic KIND_CHECKSUM  = 1'b1;

    typedef struct packed {
        logic               bad;
        logic [7:0]         status_first;
        logic [7:0]         status_second;
        logic [11:0]        zoom_tenths;
        logic signed [15:0] sight_x;
        logic signed [15:0] sight_y;
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic [15:0]        range_tenths;
        logic [7:0]         self_test;
    } tfr_rec_t;

endpackage

@@ rtl/tfr_front.sv @@
// Front end of the telemetry frame receiver: sync hunt, byte capture,
// running checksum and record push. Depends on tfr_pkg.
module tfr_front
    import tfr_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_valid,
    input  logic [7:0]     rx_byte,
    output logic           rec_push,
    output tfr_rec_t       rec_data
);

    localparam logic [POS_W-1:0] POS_START     = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SYNC2     = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LAST      = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_STATUS1   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_STATUS2   = POS_W'(3);
    localparam logic [POS_W-1:0] POS_ZOOM_LO   = POS_W'(4);
    localparam logic [POS_W-1:0] POS_ZOOM_HI   = POS_W'(5);
    localparam logic [POS_W-1:0] POS_SX_LO     = POS_W'(6);
    localparam logic [POS_W-1:0] POS_SX_HI     = POS_W'(7);
    localparam logic [POS_W-1:0] POS_SY_LO     = POS_W'(8);
    localparam logic [POS_W-1:0] POS_SY_HI     = POS_W'(9);
    localparam logic [POS_W-1:0] POS_ROLL_LO   = POS_W'(10);
    localparam logic [POS_W-1:0] POS_ROLL_HI   = POS_W'(11);
    localparam logic [POS_W-1:0] POS_PITCH_LO  = POS_W'(12);
    localparam logic [POS_W-1:0] POS_PITCH_HI  = POS_W'(13);
    localparam logic [POS_W-1:0] POS_YAW_LO    = POS_W'(14);
    localparam logic [POS_W-1:0] POS_YAW_HI    = POS_W'(15);
    localparam logic [POS_W-1:0] POS_RANGE_LO  = POS_W'(26);
    localparam logic [POS_W-1:0] POS_RANGE_HI  = POS_W'(27);
    localparam logic [POS_W-1:0] POS_SELF_TEST = POS_W'(28);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             expect_reg, expect_next;
    logic [7:0]       sum_reg, sum_next;
    logic             capture;

    logic [7:0]  status_first_reg;
    logic [7:0]  status_second_reg;
    logic [11:0] zoom_reg;
    logic [15:0] sight_x_reg;
    logic [15:0] sight_y_reg;
    logic [15:0] roll_reg;
    logic [15:0] pitch_reg;
    logic [15:0] yaw_reg;
    logic [15:0] range_reg;
    logic [7:0]  self_test_reg;

    always_comb
    begin
        pos_next    = pos_reg;
        expect_next = expect_reg;
        sum_next    = sum_reg;
        capture     = 1'b0;
        rec_push    = 1'b0;
        if (byte_valid)
        begin
            if (pos_reg == POS_START)
            begin
                if (rx_byte == SYNC_FIRST)
                begin
                    sum_next    = SYNC_FIRST;
                    pos_next    = POS_START + POS_W'(1);
                    expect_next = 1'b1;
                end
            end
            else if (expect_reg)
            begin
                if (rx_byte == SYNC_SECOND)
                begin
                    sum_next    = sum_reg + rx_byte;
                    pos_next    = POS_SYNC2;
                    expect_next = 1'b0;
                end
                else if (rx_byte == SYNC_FIRST)
                begin
                    // restart the frame on a repeated first sync byte
                    sum_next = SYNC_FIRST;
                    pos_next = POS_START + POS_W'(1);
                end
                else
                begin
                    sum_next    = 8'h00;
                    pos_next    = POS_START;
                    expect_next = 1'b0;
                end
            end
            else if (pos_reg != POS_LAST)
            begin
                capture  = 1'b1;
                sum_next = sum_reg + rx_byte;
                pos_next = pos_reg + POS_W'(1);
            end
            else
            begin
                rec_push    = 1'b1;
                sum_next    = 8'h00;
                pos_next    = POS_START;
                expect_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        rec_data.bad           = (sum_reg != rx_byte);
        rec_data.status_first  = status_first_reg;
        rec_data.status_second = status_second_reg;
        rec_data.zoom_tenths   = zoom_reg;
        rec_data.sight_x       = sight_x_reg;
        rec_data.sight_y       = sight_y_reg;
        rec_data.roll_angle    = roll_reg;
        rec_data.pitch_angle   = pitch_reg;
        rec_data.yaw_angle     = yaw_reg;
        rec_data.range_tenths  = range_reg;
        rec_data.self_test     = self_test_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_START;
            expect_reg <= 1'b0;
            sum_reg    <= 8'h00;
        end
        else
        begin
            pos_reg    <= pos_next;
            expect_reg <= expect_next;
            sum_reg    <= sum_next;
        end
    end

    // keep only the frame bytes that the decoded record uses
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            case (pos_reg)
                POS_STATUS1:   status_first_reg    <= rx_byte;
                POS_STATUS2:   status_second_reg   <= rx_byte;
                POS_ZOOM_LO:   zoom_reg[7:0]       <= rx_byte;
                POS_ZOOM_HI:   zoom_reg[11:8]      <= rx_byte[3:0] & ZOOM_HIGH_MASK[3:0];
                POS_SX_LO:     sight_x_reg[7:0]    <= rx_byte;
                POS_SX_HI:     sight_x_reg[15:8]   <= rx_byte;
                POS_SY_LO:     sight_y_reg[7:0]    <= rx_byte;
                POS_SY_HI:     sight_y_reg[15:8]   <= rx_byte;
                POS_ROLL_LO:   roll_reg[7:0]       <= rx_byte;
                POS_ROLL_HI:   roll_reg[15:8]      <= rx_byte;
                POS_PITCH_LO:  pitch_reg[7:0]      <= rx_byte;
                POS_PITCH_HI:  pitch_reg[15:8]     <= rx_byte;
                POS_YAW_LO:    yaw_reg[7:0]        <= rx_byte;
                POS_YAW_HI:    yaw_reg[15:8]       <= rx_byte;
                POS_RANGE_LO:  range_reg[7:0]      <= rx_byte;
                POS_RANGE_HI:  range_reg[15:8]     <= rx_byte;
                POS_SELF_TEST: self_test_reg       <= rx_byte;
                default:       ;
            endcase
        end
    end

endmodule

@@ rtl/tfr_queue.sv @@
// Two-entry record queue between front and back of the frame receiver.
// Depends on tfr_pkg.
module tfr_queue
    import tfr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  tfr_rec_t wr_data,
    output logic     q_full,
    input  logic     rd_en,
    output logic     rd_valid,
    output tfr_rec_t rd_data
);

    tfr_rec_t              entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg, count_next;

    assign q_full   = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + (QUEUE_AW+1)'(1);
            2'b01:   count_next = count_reg - (QUEUE_AW+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entries_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

@@ rtl/tfr_back.sv @@
// Back end of the frame receiver: valid frame count and result register.
// Depends on tfr_pkg.
module tfr_back
    import tfr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_valid,
    input  tfr_rec_t           rd_data,
    output logic               rd_en,
    output logic               empty,
    input  logic               pop,
    output logic               result_kind,
    output logic [31:0]        frames_seen,
    output logic [7:0]         status_first,
    output logic [7:0]         status_second,
    output logic [11:0]        zoom_tenths,
    output logic signed [15:0] sight_x,
    output logic signed [15:0] sight_y,
    output logic signed [15:0] roll_angle,
    output logic signed [15:0] pitch_angle,
    output logic signed [15:0] yaw_angle,
    output logic [15:0]        range_tenths,
    output logic [7:0]         self_test
);

    logic        out_valid_reg;
    logic [31:0] count_reg, count_next;
    logic [31:0] frames_seen_reg;
    tfr_rec_t    out_rec_reg, out_rec_next;

    // refill the result register when it is free or being drained
    assign rd_en = rd_valid && (!out_valid_reg || pop);

    always_comb
    begin
        count_next   = count_reg;
        out_rec_next = rd_data;
        if (rd_data.bad)
        begin
            out_rec_next     = '0;
            out_rec_next.bad = KIND_CHECKSUM;
        end
        else
            count_next = count_reg + 32'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= 32'd0;
        end
        else
        begin
            if (rd_en)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            out_rec_reg     <= out_rec_next;
            frames_seen_reg <= count_next;
        end
    end

    assign empty         = !out_valid_reg;
    assign result_kind   = out_rec_reg.bad;
    assign frames_seen   = frames_seen_reg;
    assign status_first  = out_rec_reg.status_first;
    assign status_second = out_rec_reg.status_second;
    assign zoom_tenths   = out_rec_reg.zoom_tenths;
    assign sight_x       = out_rec_reg.sight_x;
    assign sight_y       = out_rec_reg.sight_y;
    assign roll_angle    = out_rec_reg.roll_angle;
    assign pitch_angle   = out_rec_reg.pitch_angle;
    assign yaw_angle     = out_rec_reg.yaw_angle;
    assign range_tenths  = out_rec_reg.range_tenths;
    assign self_test     = out_rec_reg.self_test;

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 32'd1))
        else $error("valid frame count moved by more than one");

    a_seen_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (frames_seen_reg == count_reg))
        else $error("shown frame count differs from running count");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(frames_seen_reg)
                                     && $stable(out_rec_reg)))
        else $error("result changed while stalled");

    a_bad_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_rec_reg.bad) |-> (out_rec_reg.status_first == 8'h00
                                                && out_rec_reg.range_tenths == 16'h0000))
        else $error("checksum error result carries frame data");

endmodule

@@ rtl/telemetry_frame_receiver.sv @@
// Top level of the telemetry frame receiver: byte parser front end, record
// queue and result back end. Depends on tfr_pkg, tfr_front, tfr_queue, tfr_back.
//
// Usage:
//  - Input channel: one serial byte on rx_byte per transfer. A transfer
//    happens at a rising edge with push high and full low. Bytes are taken
//    one per cycle while full is low; full rises only when two decoded frames
//    wait in the record queue and a third is held in the result register.
//  - The front end hunts for 0xEE then 0x16, keeps the 8-bit sum of the
//    first 31 bytes and, on the 32nd byte, pushes one record (decoded frame
//    or checksum error) into a two-entry queue. Other bytes give no result.
//  - Result channel: the oldest result sits on the result ports while empty
//    is low; a transfer happens at a rising edge with pop high and empty low.
//  - Timing: a frame's record enters the queue at the edge that takes its 32nd
//    byte and shows on the result ports once the result register takes it.
//    Throughput is one byte per cycle while full is low, set by the compare-store-add in the
//    front end and the one-per-cycle refill of the result register.
//  - Stall: while pop stays low the result holds; the queue absorbs two more
//    frames before full stalls the byte stream.
//  - Reset (rst_n low, asynchronous): drop any partial frame, clear the
//    queue, mark the result register empty and clear the valid frame count.
module telemetry_frame_receiver
    import tfr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         rx_byte,
    output logic               empty,
    input  logic               pop,
    output logic               result_kind,
    output logic [31:0]        frames_seen,
    output logic [7:0]         status_first,
    output logic [7:0]         status_second,
    output logic [11:0]        zoom_tenths,
    output logic signed [15:0] sight_x,
    output logic signed [15:0] sight_y,
    output logic signed [15:0] roll_angle,
    output logic signed [15:0] pitch_angle,
    output logic signed [15:0] yaw_angle,
    output logic [15:0]        range_tenths,
    output logic [7:0]         self_test
);

    logic     byte_valid;
    logic     rec_push;
    tfr_rec_t rec_data;
    logic     q_full;
    logic     rd_en;
    logic     rd_valid;
    tfr_rec_t rd_data;

    // a byte transfers only while the record queue has room
    assign full       = q_full;
    assign byte_valid = push && !q_full;

    tfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .rx_byte    (rx_byte),
        .rec_push   (rec_push),
        .rec_data   (rec_data)
    );

    tfr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (rec_push),
        .wr_data  (rec_data),
        .q_full   (q_full),
        .rd_en    (rd_en),
        .rd_valid (rd_valid),
        .rd_data  (rd_data)
    );

    tfr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .rd_valid      (rd_valid),
        .rd_data       (rd_data),
        .rd_en         (rd_en),
        .empty         (empty),
        .pop           (pop),
        .result_kind   (result_kind),
        .frames_seen   (frames_seen),
        .status_first  (status_first),
        .status_second (status_second),
        .zoom_tenths   (zoom_tenths),
        .sight_x       (sight_x),
        .sight_y       (sight_y),
        .roll_angle    (roll_angle),
        .pitch_angle   (pitch_angle),
        .yaw_angle     (yaw_angle),
        .range_tenths  (range_tenths),
        .self_test     (self_test)
    );

endmodule

@@ tb/tb.sv @@
// Testbench for telemetry_frame_receiver: drives serial bytes in, checks every
// decoded frame and checksum error against a frame decoder kept in the bench.
// Depends on tfr_pkg and the telemetry_frame_receiver RTL.
module tb
    import tfr_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no transfer on either side
    localparam int RANDOM_BYTES   = 800;
    localparam int HOLD_CYCLES    = 400;    // long receiver hold-off to fill the queue
    localparam int DRAIN_CYCLES   = 8;      // idle wait after the last pending result is checked
    localparam int PRINT_LIMIT    = 40;

    // One expected result, laid out like the result ports.
    typedef struct packed {
        logic               result_kind;
        logic [31:0]        frames_seen;
        logic [7:0]         status_first;
        logic [7:0]         status_second;
        logic [11:0]        zoom_tenths;
        logic signed [15:0] sight_x;
        logic signed [15:0] sight_y;
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic [15:0]        range_tenths;
        logic [7:0]         self_test;
    } telemetry_t;

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               push    = 1'b0;
    logic [7:0]         rx_byte = 8'h00;
    logic               pop     = 1'b0;
    logic               full;
    logic               empty;
    logic               result_kind;
    logic [31:0]        frames_seen;
    logic [7:0]         status_first;
    logic [7:0]         status_second;
    logic [11:0]        zoom_tenths;
    logic signed [15:0] sight_x;
    logic signed [15:0] sight_y;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic [15:0]        range_tenths;
    logic [7:0]         self_test;

    always #1 clk = ~clk;

    telemetry_frame_receiver u_top (.*);

    // Frame decoder state, mirrors the parser after reset.
    logic [5:0]  rx_pos           = '0;
    logic        wait_sync2       = 1'b0;
    logic [7:0]  rx_sum           = '0;
    logic [7:0]  frame_buf [FRAME_BYTES];
    logic [31:0] good_frame_count = '0;

    telemetry_t  pending_frames [$];   // decoded results not yet popped
    int          error_count      = 0;
    int          bytes_sent       = 0;

    // Traffic shaping shared between the sender, the sink and the tests.
    bit          tx_calm      = 1'b0;
    bit          rx_calm      = 1'b0;
    int          hold_request = 0;
    logic [7:0]  tx_frame [FRAME_BYTES];

    // ------------------------------------------------------------------
    // Frame decoder
    // ------------------------------------------------------------------

    // Hold one byte of the current frame and add it into the running sum.
    task automatic store_byte(input logic [7:0] b);
        frame_buf[rx_pos[4:0]] = b;
        rx_sum = rx_sum + b;
        rx_pos = rx_pos + 6'd1;
    endtask

    // Advance the decoder by one accepted byte; queue a result on the 32nd.
    task automatic decode_rx_byte(input logic [7:0] b);
        telemetry_t r;
        logic [7:0] zoom_hi;
        if (rx_pos == 0)
        begin
            // Hunting: only the first sync byte opens a frame.
            if (b == SYNC_FIRST)
            begin
                rx_sum = '0;
                store_byte(b);
                wait_sync2 = 1'b1;
            end
        end
        else if (wait_sync2)
        begin
            if (b == SYNC_SECOND)
            begin
                store_byte(b);
                wait_sync2 = 1'b0;
            end
            else if (b == SYNC_FIRST)
            begin
                // Repeated first sync byte: restart with it as byte 0.
                rx_pos = '0;
                rx_sum = '0;
                store_byte(b);
            end
            else
            begin
                rx_pos = '0;
                rx_sum = '0;
                wait_sync2 = 1'b0;
            end
        end
        else if (rx_pos < FRAME_BYTES - 1)
        begin
            store_byte(b);
        end
        else
        begin
            frame_buf[FRAME_BYTES - 1] = b;
            r = '0;
            if (rx_sum != b)
            begin
                // Checksum error: count is reported unchanged, all else zero.
                r.result_kind = KIND_CHECKSUM;
                r.frames_seen = good_frame_count;
            end
            else
            begin
                good_frame_count = good_frame_count + 32'd1;
                zoom_hi = frame_buf[5] & ZOOM_HIGH_MASK;
                r.result_kind   = KIND_VALID;
                r.frames_seen   = good_frame_count;
                r.status_first  = frame_buf[2];
                r.status_second = frame_buf[3];
                r.zoom_tenths   = {zoom_hi[3:0], frame_buf[4]};
                r.sight_x       = {frame_buf[7], frame_buf[6]};
                r.sight_y       = {frame_buf[9], frame_buf[8]};
                r.roll_angle    = {frame_buf[11], frame_buf[10]};
                r.pitch_angle   = {frame_buf[13], frame_buf[12]};
                r.yaw_angle     = {frame_buf[15], frame_buf[14]};
                r.range_tenths  = {frame_buf[27], frame_buf[26]};
                r.self_test     = frame_buf[28];
            end
            pending_frames.push_back(r);
            rx_pos = '0;
            rx_sum = '0;
            wait_sync2 = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < PRINT_LIMIT)
            $display("ERROR at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Compare the result on the ports against the oldest pending one.
    task automatic check_result();
        telemetry_t want;
        if (pending_frames.size() == 0)
        begin
            report_mismatch("result with nothing pending, frames_seen", frames_seen, '0);
        end
        else
        begin
            want = pending_frames.pop_front();
            check_field("result_kind",   32'(result_kind),   32'(want.result_kind));
            check_field("frames_seen",   frames_seen,        want.frames_seen);
            check_field("status_first",  32'(status_first),  32'(want.status_first));
            check_field("status_second", 32'(status_second), 32'(want.status_second));
            check_field("zoom_tenths",   32'(zoom_tenths),   32'(want.zoom_tenths));
            check_field("sight_x",       32'(sight_x),       32'(want.sight_x));
            check_field("sight_y",       32'(sight_y),       32'(want.sight_y));
            check_field("roll_angle",    32'(roll_angle),    32'(want.roll_angle));
            check_field("pitch_angle",   32'(pitch_angle),   32'(want.pitch_angle));
            check_field("yaw_angle",     32'(yaw_angle),     32'(want.yaw_angle));
            check_field("range_tenths",  32'(range_tenths),  32'(want.range_tenths));
            check_field("self_test",     32'(self_test),     32'(want.self_test));
        end
    endtask

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Gap length: mostly none, some short, a few long.
    function automatic int pick_idle();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Drop push for a random gap; leave it alone when there is no gap so a
    // back-to-back transfer never lowers and raises push in one step.
    task automatic tx_pause();
        int n;
        n = tx_calm ? 0 : pick_idle();
        if (n > 0)
        begin
            push <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Offer one byte and hold it until the block takes it.
    task automatic send_byte(input logic [7:0] b);
        push    <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full) @(posedge clk);
        decode_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic offer_byte(input logic [7:0] b);
        tx_pause();
        send_byte(b);
    endtask

    task automatic put_word(input int idx, input logic [15:0] v);
        tx_frame[idx]     = v[7:0];
        tx_frame[idx + 1] = v[15:8];
    endtask

    task automatic fill_random_body();
        for (int i = 2; i < FRAME_BYTES - 1; i++)
            tx_frame[i] = 8'($urandom);
    endtask

    // Add the sync bytes and checksum to tx_frame and send it; flip some
    // checksum bits when a checksum error is wanted.
    task automatic send_frame(input bit corrupt);
        logic [7:0] sum;
        logic [7:0] flip;
        tx_frame[0] = SYNC_FIRST;
        tx_frame[1] = SYNC_SECOND;
        sum = '0;
        for (int i = 0; i < FRAME_BYTES - 1; i++)
            sum = sum + tx_frame[i];
        flip = corrupt ? 8'($urandom_range(1, 255)) : 8'h00;
        tx_frame[FRAME_BYTES - 1] = sum ^ flip;
        for (int i = 0; i < FRAME_BYTES; i++)
            offer_byte(tx_frame[i]);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Drop bytes while hunting, fall back on a bad second sync byte, restart
    // on a repeated first sync byte, then finish a frame with high extremes.
    task automatic test_sync_hunt();
        offer_byte(8'h00);
        offer_byte(8'hFF);
        offer_byte(SYNC_SECOND);
        offer_byte(SYNC_FIRST);
        offer_byte(8'h55);
        offer_byte(SYNC_FIRST);      // frame below opens with a second one
        fill_random_body();
        tx_frame[2] = 8'hFF;
        tx_frame[3] = 8'hFF;
        tx_frame[4] = 8'hFF;
        tx_frame[5] = 8'hFF;         // upper nibble must be masked off the zoom
        put_word(6, 16'h7FFF);
        put_word(8, 16'h8000);
        put_word(10, 16'hFFFF);
        put_word(12, 16'h0000);
        put_word(14, 16'h7FFF);
        put_word(26, 16'hFFFF);
        tx_frame[28] = 8'hFF;
        send_frame(1'b0);
    endtask

    // Low extremes: zero status, zero zoom with only high nibble set in
    // byte 5, most negative angles, range of zero meaning no measurement.
    task automatic test_field_extremes();
        fill_random_body();
        tx_frame[2] = 8'h00;
        tx_frame[3] = 8'h00;
        tx_frame[4] = 8'h00;
        tx_frame[5] = 8'hF0;
        put_word(6, 16'h8000);
        put_word(8, 16'h7FFF);
        put_word(10, 16'h8000);
        put_word(12, 16'h8000);
        put_word(14, 16'h8000);
        put_word(26, 16'h0000);
        tx_frame[28] = 8'h00;
        send_frame(1'b0);
    endtask

    // Checksum error keeps the count; then a valid all-0xFF body whose sum
    // wraps many times over.
    task automatic test_checksum_error();
        fill_random_body();
        send_frame(1'b1);
        for (int i = 2; i < FRAME_BYTES - 1; i++)
            tx_frame[i] = 8'hFF;
        send_frame(1'b0);
    endtask

    // Hold the sink off for a long stretch while frames stream in back to
    // back, so the record queue fills and full stalls the byte stream.
    task automatic test_back_pressure();
        hold_request = HOLD_CYCLES;
        tx_calm = 1'b1;
        repeat (5)
        begin
            fill_random_body();
            send_frame(1'b0);
        end
        tx_calm = 1'b0;
    endtask

    // Mostly well-formed frames with random content, plus noise and broken
    // sync sequences; switch quiet stretches on and off along the way.
    task automatic test_random_traffic();
        int first_byte;
        int pick;
        int n;
        logic [7:0] b;
        first_byte = bytes_sent;
        while (bytes_sent - first_byte < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                tx_calm = ($urandom_range(0, 2) == 0);
                rx_calm = ($urandom_range(0, 2) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                n = $urandom_range(0, 2);
                repeat (n) offer_byte(8'($urandom));
                fill_random_body();
                if ($urandom_range(0, 5) == 0)
                begin
                    put_word(6 + 2 * int'($urandom_range(0, 4)),
                             $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF);
                    put_word(26, $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF);
                end
                send_frame($urandom_range(0, 7) == 0);
            end
            else if (pick < 85)
            begin
                n = $urandom_range(1, 8);
                repeat (n)
                begin
                    b = 8'($urandom);
                    if ($urandom_range(0, 3) == 0)
                        b = SYNC_FIRST;
                    offer_byte(b);
                end
            end
            else
            begin
                // Broken opening: first sync byte, then a repeat or a wrong byte.
                b = 8'($urandom);
                if (b == SYNC_SECOND || $urandom_range(0, 1) == 0)
                    b = SYNC_FIRST;
                offer_byte(SYNC_FIRST);
                offer_byte(b);
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result sink: pop with random stalls, honor long hold-off requests.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                check_result();
            if (hold_request > 0)
            begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                pop <= 1'b1;
                if (!rx_calm && $urandom_range(0, 3) == 0)
                    stall_left = pick_idle();
            end
        end
    end

    // Watchdog: end the run when neither side has had a transfer for too long.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // Main sequence: reset once, run each test, drain, give the verdict.
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_sync_hunt();
        test_field_extremes();
        test_checksum_error();
        test_back_pressure();
        test_random_traffic();
        push <= 1'b0;
        while (pending_frames.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/tfr_pkg.sv
rtl/tfr_front.sv
rtl/tfr_queue.sv
rtl/tfr_back.sv
rtl/telemetry_frame_receiver.sv
tb/tb.sv
